@@ rtl/rtts_pkg.sv @@
// Shared constants and types for the round-trip-time statistics block.
// Used by rtts_roundtrip, rtts_divmul, rtt_running_statistics and the testbench; depends on nothing.
package rtts_pkg;

  localparam int SEC_BITS     = 32;
  localparam int USEC_BITS    = 20;
  localparam int IN_W         = 2 * (SEC_BITS + USEC_BITS);
  localparam int COUNT_BITS   = 32;
  localparam int DEV_BITS     = 64;
  localparam int FRAC_BITS    = 8;
  localparam int MS_PER_SEC   = 1000;
  localparam int USEC_PER_SEC = MS_PER_SEC * 1000;

  typedef enum logic {
    DM_DIV = 1'b0,
    DM_MUL = 1'b1
  } dm_op_t;

  typedef struct packed {
    logic   start;
    dm_op_t op;
  } dm_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dm_stat_t;

endpackage

@@ rtl/rtts_roundtrip.sv @@
// Three-stage round trip time calculation with clamping to TIME_BITS.
// Depends on rtts_pkg.
module rtts_roundtrip
  import rtts_pkg::*;
#(
  parameter int TIME_BITS = 26
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [SEC_BITS-1:0]  sent_sec,
  input  logic [USEC_BITS-1:0] sent_usec,
  input  logic [SEC_BITS-1:0]  now_sec,
  input  logic [USEC_BITS-1:0] now_usec,
  output logic                 done,
  output logic [TIME_BITS-1:0] rtt
);

  localparam int DS_W   = SEC_BITS + 1;
  localparam int DU_W   = USEC_BITS + 1;
  localparam int PROD_W = DS_W + DU_W;
  localparam int T_W    = PROD_W + 1;
  localparam logic signed [DU_W-1:0] USEC_S = DU_W'(USEC_PER_SEC);

  logic                     v1, v2;
  logic signed [DS_W-1:0]   ds;
  logic signed [DU_W-1:0]   du, du2;
  logic signed [PROD_W-1:0] prod;
  logic signed [T_W-1:0]    t_sum;
  logic [TIME_BITS-1:0]     rtt_next;

  always_comb begin
    t_sum = T_W'(prod) + T_W'(du2);
    if (t_sum[T_W-1]) begin
      rtt_next = '0;
    end else if (|t_sum[T_W-2:TIME_BITS]) begin
      rtt_next = '1;
    end else begin
      rtt_next = t_sum[TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ds <= $signed({1'b0, now_sec}) - $signed({1'b0, sent_sec});
      du <= $signed({1'b0, now_usec}) - $signed({1'b0, sent_usec});
    end
    if (v1) begin
      prod <= PROD_W'(ds) * PROD_W'(USEC_S);
      du2  <= du;
    end
    if (v2) begin
      rtt <= rtt_next;
    end
  end

endmodule

@@ rtl/rtts_divmul.sv @@
// Bit-serial unit around one shared adder: restoring division or shift-add
// multiplication, one bit per cycle. Depends on rtts_pkg.
module rtts_divmul
  import rtts_pkg::*;
#(
  parameter int OPW  = 34,
  parameter int ADDW = 35
) (
  input  logic            clk,
  input  logic            rst,
  input  dm_ctrl_t        ctrl,
  input  logic [OPW-1:0]  opa,
  input  logic [ADDW-1:0] opb,
  output dm_stat_t        stat,
  output logic [OPW-1:0]  res_hi,
  output logic [OPW-1:0]  res_lo
);

  localparam int CW = $clog2(OPW + 1);

  logic [ADDW-1:0] hi, opnd, shifted, add_a, add_b;
  logic [OPW-1:0]  lo;
  logic [ADDW:0]   add_sum;
  logic            cin;
  dm_op_t          op_q;
  logic            busy, done;
  logic [CW-1:0]   cnt;

  always_comb begin
    shifted = {hi[ADDW-2:0], lo[OPW-1]};
    if (op_q == DM_DIV) begin
      add_a = shifted;
      add_b = ~opnd;
      cin   = 1'b1;
    end else begin
      add_a = hi;
      add_b = lo[0] ? opnd : '0;
      cin   = 1'b0;
    end
    add_sum = {1'b0, add_a} + {1'b0, add_b} + (ADDW + 1)'(cin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op_q <= DM_DIV;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= CW'(OPW - 1);
        op_q <= ctrl.op;
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      hi   <= '0;
      lo   <= opa;
      opnd <= opb;
    end else if (busy) begin
      if (op_q == DM_DIV) begin
        hi <= add_sum[ADDW] ? add_sum[ADDW-1:0] : shifted;
        lo <= {lo[OPW-2:0], add_sum[ADDW]};
      end else begin
        hi <= add_sum[ADDW:1];
        lo <= {add_sum[0], lo[OPW-1:1]};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign res_hi    = hi[OPW-1:0];
  assign res_lo    = lo;

endmodule

@@ rtl/rtt_running_statistics.sv @@
// Top level of the round-trip-time statistics block: sequencer, statistics
// registers and output register. Depends on rtts_pkg, rtts_roundtrip, rtts_divmul.
//
// Each input transfer carries a send and a receive timestamp; the block forms
// the clamped round trip time in microseconds and updates the sample count,
// minimum, maximum, saturating sum, running mean and Welford's saturating sum
// of squared deviations (mean and deviation sum in fixed point with 8
// fractional bits), then returns all of them in one output transfer. A
// new input is taken only after the current one has passed the three-stage
// round trip pipeline and the bit-serial divide and multiply unit, which
// forms the mean quotient and then the deviation product, and has been
// placed in the output register. s_tready is low while an item is in work;
// a finished result waits in the output register while the next input is
// accepted.
module rtt_running_statistics
  import rtts_pkg::*;
#(
  parameter int TIME_BITS = 26
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // sent_sec, sent_usec, now_sec, now_usec
  input  logic [IN_W-1:0]                           s_tdata,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // rtt_us, sample_count, min_rtt, max_rtt, rtt_sum, mean_rtt, sq_dev_sum
  output logic [((5*TIME_BITS+136+7)/8)*8-1:0]      m_tdata
);

  localparam int OUT_W     = ((5 * TIME_BITS + 136 + 7) / 8) * 8;
  localparam int SUM_BITS  = TIME_BITS + COUNT_BITS;
  localparam int MEAN_BITS = TIME_BITS + FRAC_BITS;
  localparam int ADD_W     = (MEAN_BITS > COUNT_BITS) ? MEAN_BITS + 1 : COUNT_BITS + 1;
  localparam int PROD_W    = 2 * MEAN_BITS;
  localparam int INC_W     = PROD_W - FRAC_BITS;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_RTT   = 10'b00_0000_0010,
    ST_STATS = 10'b00_0000_0100,
    ST_DIV   = 10'b00_0000_1000,
    ST_MEAN  = 10'b00_0001_0000,
    ST_MULGO = 10'b00_0010_0000,
    ST_MUL   = 10'b00_0100_0000,
    ST_DEV   = 10'b00_1000_0000,
    ST_EMIT  = 10'b01_0000_0000,
    ST_SPARE = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  logic [COUNT_BITS-1:0] count_reg, count_next;
  logic [TIME_BITS-1:0]  min_reg, max_reg;
  logic [SUM_BITS-1:0]   sum_reg;
  logic [SUM_BITS:0]     sum_add;
  logic [MEAN_BITS-1:0]  mean_reg, x_reg, dmag_reg;
  logic [MEAN_BITS-1:0]  x_calc, dmag_calc, rmag_calc, mean_next;
  logic                  neg_reg, neg_calc;
  logic [DEV_BITS-1:0]   dev_reg, inc;
  logic [DEV_BITS:0]     dev_add;
  logic [PROD_W-1:0]     prod;
  logic [INC_W+DEV_BITS-1:0] inc_ext;

  logic                 accept, rt_done, out_free;
  logic [TIME_BITS-1:0] rtt;

  dm_ctrl_t             dm_ctrl;
  dm_stat_t             dm_stat;
  logic [MEAN_BITS-1:0] dm_opa, dm_hi, dm_lo;
  logic [ADD_W-1:0]     dm_opb;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;

  rtts_roundtrip #(
    .TIME_BITS(TIME_BITS)
  ) u_roundtrip (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .sent_sec (s_tdata[SEC_BITS-1:0]),
    .sent_usec(s_tdata[SEC_BITS+USEC_BITS-1:SEC_BITS]),
    .now_sec  (s_tdata[2*SEC_BITS+USEC_BITS-1:SEC_BITS+USEC_BITS]),
    .now_usec (s_tdata[IN_W-1:2*SEC_BITS+USEC_BITS]),
    .done     (rt_done),
    .rtt      (rtt)
  );

  rtts_divmul #(
    .OPW (MEAN_BITS),
    .ADDW(ADD_W)
  ) u_divmul (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (dm_ctrl),
    .opa   (dm_opa),
    .opb   (dm_opb),
    .stat  (dm_stat),
    .res_hi(dm_hi),
    .res_lo(dm_lo)
  );

  always_comb begin
    count_next = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    sum_add    = {1'b0, sum_reg} + (SUM_BITS + 1)'(rtt);
    x_calc     = {rtt, FRAC_BITS'(0)};
    neg_calc   = x_calc < mean_reg;
    dmag_calc  = neg_calc ? mean_reg - x_calc : x_calc - mean_reg;
    mean_next  = neg_reg ? mean_reg - dm_lo : mean_reg + dm_lo;
    rmag_calc  = neg_reg ? mean_reg - x_reg : x_reg - mean_reg;
    prod       = {dm_hi, dm_lo};
    inc_ext    = {DEV_BITS'(0), prod[PROD_W-1:FRAC_BITS]};
    inc        = (|inc_ext[INC_W+DEV_BITS-1:DEV_BITS]) ? '1 : inc_ext[DEV_BITS-1:0];
    dev_add    = {1'b0, dev_reg} + {1'b0, inc};
  end

  always_comb begin
    dm_ctrl.start = ((state == ST_STATS) || (state == ST_MULGO)) && !dm_stat.busy;
    dm_ctrl.op    = (state == ST_MULGO) ? DM_MUL : DM_DIV;
    dm_opa        = (state == ST_MULGO) ? rmag_calc : dmag_calc;
    dm_opb        = (state == ST_MULGO) ? ADD_W'(dmag_reg) : ADD_W'(count_next);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_RTT;
      ST_RTT:   if (rt_done) state_next = ST_STATS;
      ST_STATS: state_next = ST_DIV;
      ST_DIV:   if (dm_stat.done) state_next = ST_MEAN;
      ST_MEAN:  state_next = ST_MULGO;
      ST_MULGO: state_next = ST_MUL;
      ST_MUL:   if (dm_stat.done) state_next = ST_DEV;
      ST_DEV:   state_next = ST_EMIT;
      ST_EMIT:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count_reg <= '0;
      min_reg   <= '1;
      max_reg   <= '0;
      sum_reg   <= '0;
      mean_reg  <= '0;
      dev_reg   <= '0;
      x_reg     <= '0;
      dmag_reg  <= '0;
      neg_reg   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_STATS) begin
        count_reg <= count_next;
        if (rtt > max_reg) max_reg <= rtt;
        if (rtt < min_reg) min_reg <= rtt;
        sum_reg  <= sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
        x_reg    <= x_calc;
        dmag_reg <= dmag_calc;
        neg_reg  <= neg_calc;
      end
      if (state == ST_MEAN) begin
        mean_reg <= mean_next;
      end
      if (state == ST_DEV) begin
        dev_reg <= dev_add[DEV_BITS] ? '1 : dev_add[DEV_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_EMIT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && out_free) begin
      m_tdata <= OUT_W'({dev_reg, mean_reg, sum_reg, max_reg, min_reg, count_reg,
                         rtt});
    end
  end

endmodule

@@ rtl/rtts_checker.sv @@
// Port-level checks for the round-trip-time statistics block and their bind.
// Depends on rtt_running_statistics.
module rtts_checker #(
  parameter int TIME_BITS = 26
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_tvalid,
  input logic                                 s_tready,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [((5*TIME_BITS+136+7)/8)*8-1:0] m_tdata
);

  localparam int CNT_LO = TIME_BITS;
  localparam int MIN_LO = TIME_BITS + 32;
  localparam int MAX_LO = 2 * TIME_BITS + 32;

  logic [TIME_BITS-1:0] rtt_f, min_f, max_f;
  logic [31:0]          cnt_f;

  assign rtt_f = m_tdata[TIME_BITS-1:0];
  assign cnt_f = m_tdata[CNT_LO+31:CNT_LO];
  assign min_f = m_tdata[MIN_LO+TIME_BITS-1:MIN_LO];
  assign max_f = m_tdata[MAX_LO+TIME_BITS-1:MAX_LO];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in work");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> cnt_f != 32'd0)
    else $error("result with zero sample count");

  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> min_f <= rtt_f && rtt_f <= max_f)
    else $error("sample outside the minimum to maximum range");

endmodule

bind rtt_running_statistics rtts_checker #(
  .TIME_BITS(TIME_BITS)
) u_rtts_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

@@ sim/rtt_running_statistics_tb.sv @@
// Self-checking testbench for rtt_running_statistics: drives timestamp pairs
// over the input stream and checks every statistics transfer on the output.
// Depends on rtts_pkg and the rtt_running_statistics RTL.
module rtt_running_statistics_tb;
  import rtts_pkg::*;

  localparam int TB_TIME_BITS   = 26;
  localparam int SUM_W          = TB_TIME_BITS + 32;
  localparam int MEAN_W         = TB_TIME_BITS + FRAC_BITS;
  localparam int OUT_W          = ((5 * TB_TIME_BITS + 136 + 7) / 8) * 8;
  localparam int O_CNT          = TB_TIME_BITS;
  localparam int O_MIN          = O_CNT + COUNT_BITS;
  localparam int O_MAX          = O_MIN + TB_TIME_BITS;
  localparam int O_SUM          = O_MAX + TB_TIME_BITS;
  localparam int O_MEAN         = O_SUM + SUM_W;
  localparam int O_DEV          = O_MEAN + MEAN_W;
  localparam int RANDOM_ITEMS   = 1750;
  localparam int BURST_ITEMS    = 60;
  localparam int DRAIN_CYCLES   = 4 * TB_TIME_BITS + 100;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 600;

  typedef struct {
    logic [TB_TIME_BITS-1:0] rtt_us;
    logic [COUNT_BITS-1:0]   sample_count;
    logic [TB_TIME_BITS-1:0] min_rtt;
    logic [TB_TIME_BITS-1:0] max_rtt;
    logic [SUM_W-1:0]        rtt_sum;
    logic [MEAN_W-1:0]       mean_rtt;
    logic [DEV_BITS-1:0]     sq_dev_sum;
  } rtt_stats_t;

  class rtt_stats_scoreboard;
    rtt_stats_t              stats_q[$];
    int unsigned             errors;
    logic [COUNT_BITS-1:0]   count;
    logic [TB_TIME_BITS-1:0] min_rtt;
    logic [TB_TIME_BITS-1:0] max_rtt;
    logic [SUM_W-1:0]        rtt_sum;
    logic [MEAN_W-1:0]       mean_rtt;
    logic [DEV_BITS-1:0]     sq_dev_sum;

    function new();
      errors     = 0;
      count      = '0;
      min_rtt    = '1;
      max_rtt    = '0;
      rtt_sum    = '0;
      mean_rtt   = '0;
      sq_dev_sum = '0;
    endfunction

    function int pending();
      return stats_q.size();
    endfunction

    // Updates the running statistics for one accepted sample and queues them.
    function void note_sample(logic [SEC_BITS-1:0] ss, logic [USEC_BITS-1:0] su,
                              logic [SEC_BITS-1:0] ns, logic [USEC_BITS-1:0] nu);
      longint                  diff_us;
      longint                  top;
      logic [TB_TIME_BITS-1:0] rtt;
      logic [MEAN_W-1:0]       x;
      logic [MEAN_W-1:0]       dmag;
      logic [MEAN_W-1:0]       rmag;
      logic [MEAN_W-1:0]       quot;
      logic                    neg;
      logic [127:0]            prod;
      logic [DEV_BITS-1:0]     inc;
      logic [DEV_BITS:0]       dev_next;
      logic [SUM_W:0]          sum_next;
      rtt_stats_t              e;
      top = longint'((64'd1 << TB_TIME_BITS) - 64'd1);
      diff_us = (longint'({32'b0, ns}) - longint'({32'b0, ss})) * USEC_PER_SEC
              + (longint'({44'b0, nu}) - longint'({44'b0, su}));
      if (diff_us < 0) begin
        rtt = '0;
      end else if (diff_us > top) begin
        rtt = '1;
      end else begin
        rtt = diff_us[TB_TIME_BITS-1:0];
      end
      if (count != '1) begin
        count = count + 1'b1;
      end
      if (rtt > max_rtt) begin
        max_rtt = rtt;
      end
      if (rtt < min_rtt) begin
        min_rtt = rtt;
      end
      sum_next = {1'b0, rtt_sum} + rtt;
      rtt_sum = sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
      x = {rtt, {FRAC_BITS{1'b0}}};
      neg = x < mean_rtt;
      dmag = neg ? mean_rtt - x : x - mean_rtt;
      quot = dmag / {{(MEAN_W - COUNT_BITS){1'b0}}, count};
      mean_rtt = neg ? mean_rtt - quot : mean_rtt + quot;
      rmag = neg ? mean_rtt - x : x - mean_rtt;
      prod = {{(128 - MEAN_W){1'b0}}, dmag} * {{(128 - MEAN_W){1'b0}}, rmag};
      inc = (prod[127:64+FRAC_BITS] != '0) ? '1 : prod[63+FRAC_BITS:FRAC_BITS];
      dev_next = {1'b0, sq_dev_sum} + inc;
      sq_dev_sum = dev_next[DEV_BITS] ? '1 : dev_next[DEV_BITS-1:0];
      e.rtt_us       = rtt;
      e.sample_count = count;
      e.min_rtt      = min_rtt;
      e.max_rtt      = max_rtt;
      e.rtt_sum      = rtt_sum;
      e.mean_rtt     = mean_rtt;
      e.sq_dev_sum   = sq_dev_sum;
      stats_q.push_back(e);
    endfunction

    task report(string msg);
      if (errors < 100) begin
        $display("ERROR: %s", msg);
      end
      errors++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] exp);
      if (got !== exp) begin
        report($sformatf("%s got 0x%0h expected 0x%0h", name, got, exp));
      end
    endtask

    task check_stats(logic [OUT_W-1:0] d);
      rtt_stats_t e;
      if (stats_q.size() == 0) begin
        report("output transfer with no expected statistics");
      end else begin
        e = stats_q.pop_front();
        compare_field("rtt_us", 64'(d[0 +: TB_TIME_BITS]), 64'(e.rtt_us));
        compare_field("sample_count", 64'(d[O_CNT +: COUNT_BITS]), 64'(e.sample_count));
        compare_field("min_rtt", 64'(d[O_MIN +: TB_TIME_BITS]), 64'(e.min_rtt));
        compare_field("max_rtt", 64'(d[O_MAX +: TB_TIME_BITS]), 64'(e.max_rtt));
        compare_field("rtt_sum", 64'(d[O_SUM +: SUM_W]), 64'(e.rtt_sum));
        compare_field("mean_rtt", 64'(d[O_MEAN +: MEAN_W]), 64'(e.mean_rtt));
        compare_field("sq_dev_sum", d[O_DEV +: DEV_BITS], e.sq_dev_sum);
      end
    endtask
  endclass

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  rtt_stats_scoreboard sb = new();

  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned hold_left     = 0;
  int unsigned silent_cycles = 0;
  bit          hold_done     = 1'b0;

  rtt_running_statistics #(
    .TIME_BITS(TB_TIME_BITS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task send_sample(logic [SEC_BITS-1:0] ss, logic [USEC_BITS-1:0] su,
                   logic [SEC_BITS-1:0] ns, logic [USEC_BITS-1:0] nu);
    s_tvalid <= 1'b1;
    s_tdata  <= {nu, ns, su, ss};
    do begin
      @(posedge clk);
    end while (!s_tready);
    sb.note_sample(ss, su, ns, nu);
    items_sent++;
    if ((items_sent < 900 || items_sent >= 1200) && $urandom_range(0, 99) < 6) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 100)) @(posedge clk);
    end
  endtask

  // Sends a sample whose receive time lies rtt microseconds after the send time.
  task send_rtt(logic [SEC_BITS-1:0] ss, logic [USEC_BITS-1:0] su, longint rtt);
    longint total;
    total = longint'({32'b0, ss}) * USEC_PER_SEC + longint'({44'b0, su}) + rtt;
    send_sample(ss, su, SEC_BITS'(total / USEC_PER_SEC), USEC_BITS'(total % USEC_PER_SEC));
  endtask

  function longint pick_rtt(bit burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst) begin
      return (r < 50) ? longint'($urandom_range(0, 15))
                      : longint'((1 << TB_TIME_BITS) - 1 - $urandom_range(0, 15));
    end
    if (r < 50) begin
      return longint'($urandom_range(0, 100000));
    end else if (r < 80) begin
      return longint'($urandom_range(0, 1 << 20));
    end else if (r < 98) begin
      return longint'($urandom_range(0, 1 << 24));
    end
    return longint'((1 << TB_TIME_BITS) - 8 + $urandom_range(0, 15));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        sb.check_stats(m_tdata);
        results_seen++;
      end
      if (!hold_done && results_seen >= 300) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (results_seen >= 900 && results_seen < 1200) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 6);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      silent_cycles = 0;
    end else begin
      silent_cycles++;
    end
    if (silent_cycles >= WATCHDOG_LIMIT) begin
      $display("rtt_running_statistics test failed");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(32'd0, 20'd0, 32'd0, 20'd0);
    send_sample(32'd100, 20'd0, 32'd100, 20'd1);
    send_sample(32'd0, 20'd0, 32'd67, 20'd108863);
    send_sample(32'd0, 20'd0, 32'd67, 20'd108864);
    send_sample(32'd5, 20'd1, 32'd5, 20'd0);
    send_sample(32'hFFFFFFFF, 20'd999999, 32'd0, 20'd0);
    send_sample(32'd0, 20'd0, 32'hFFFFFFFF, 20'hFFFFF);
    send_sample(32'd10, 20'hFFFFF, 32'd11, 20'hFFFFF);
    send_sample(32'd7, 20'hFFFFF, 32'd9, 20'd0);
    send_sample(32'hFFFFFFFF, 20'hFFFFF, 32'hFFFFFFFF, 20'hFFFFF);
    send_sample(32'd1000, 20'd500000, 32'd1000, 20'd512000);
    send_sample(32'd1000, 20'd500000, 32'd1000, 20'd512000);
    send_sample(32'd2000, 20'd999999, 32'd2001, 20'd0);
    send_sample(32'd123456, 20'd250000, 32'd123456, 20'd250000);
    send_rtt(32'd55, 20'd0, 64'd1000);
    send_rtt(32'h80000000, 20'd999999, 64'd35000);
    send_rtt(32'h7FFFFFFF, 20'd524288, 64'd2500000);
    send_rtt(32'd3, 20'd17, 64'd999999);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (i >= RANDOM_ITEMS - BURST_ITEMS) begin
        send_rtt($urandom, $urandom_range(0, 999999), pick_rtt(1'b1));
      end else if (r < 82) begin
        send_rtt($urandom, $urandom_range(0, 999999), pick_rtt(1'b0));
      end else if (r < 92) begin
        send_sample($urandom, USEC_BITS'($urandom), $urandom, USEC_BITS'($urandom));
      end else begin
        send_sample(32'd42 + i, USEC_BITS'($urandom), 32'd42 + i, USEC_BITS'($urandom));
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("rtt_running_statistics test passed");
    end else begin
      $display("rtt_running_statistics test failed");
    end
    $finish;
  end

endmodule

@@ rtt_running_statistics.f @@
rtl/rtts_pkg.sv
rtl/rtts_roundtrip.sv
rtl/rtts_divmul.sv
rtl/rtt_running_statistics.sv
rtl/rtts_checker.sv
sim/rtt_running_statistics_tb.sv
